// ===== src/lfwoc_pkg.sv =====
package lfwoc_pkg;

    // Scan and histogram sizing
    localparam int MAX_SAMPLES = 1024;
    localparam int HIST_BINS   = 1024;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int BIN_W = $clog2(HIST_BINS);

    // Field widths
    localparam int RANGE_W    = 16;
    localparam int LEN_W      = 11;
    localparam int REP_W      = 11;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HCNT_W     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_SAMPLES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_REPEAT_LIMIT  = 2'd2;

    // Register reset values
    localparam logic [LEN_W-1:0]   SCAN_SAMPLES_RST = 11'd360;
    localparam logic [RANGE_W-1:0] THRESHOLD_RST    = 16'd300;
    localparam logic [REP_W-1:0]   WALL_LIMIT_RST   = 11'd2;

    // mm to cm: floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam logic [15:0] CM_RECIP  = 16'd52429;
    localparam int          CM_SHIFT  = 19;
    localparam int          PROD_W    = RANGE_W + 16;
    localparam int          CM_FULL_W = PROD_W - CM_SHIFT;

    // Saturating per-bin occurrence count
    localparam logic [HCNT_W-1:0] HC_EMPTY  = 2'd0;
    localparam logic [HCNT_W-1:0] HC_ONCE   = 2'd1;
    localparam logic [HCNT_W-1:0] HC_REPEAT = 2'd2;

    localparam logic [REP_W-1:0] REP_MAX = {REP_W{1'b1}};

    typedef enum logic [CLASS_W-1:0] {
        CLS_NO_READING = 2'd0,
        CLS_CLEAR      = 2'd1,
        CLS_WALL       = 2'd2,
        CLS_OBSTACLE   = 2'd3
    } class_t;

    typedef struct packed {
        class_t             class_code;
        logic [RANGE_W-1:0] front_min_mm;
        logic [REP_W-1:0]   repeated_values;
    } result_t;

endpackage

// ===== src/lfwoc_if.sv =====
interface lfwoc_in_if;
    logic                          valid;
    logic                          ready;
    logic [lfwoc_pkg::RANGE_W-1:0] range_mm;
    logic                          no_return;

    modport source (output valid, range_mm, no_return, input ready);
    modport sink   (input valid, range_mm, no_return, output ready);
endinterface

interface lfwoc_out_if;
    logic                          valid;
    logic                          ready;
    logic [lfwoc_pkg::CLASS_W-1:0] class_code;
    logic [lfwoc_pkg::RANGE_W-1:0] front_min_mm;
    logic [lfwoc_pkg::REP_W-1:0]   repeated_values;

    modport source (output valid, class_code, front_min_mm, repeated_values, input ready);
    modport sink   (input valid, class_code, front_min_mm, repeated_values, output ready);
endinterface

interface lfwoc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lfwoc_pkg::CFG_IDX_W-1:0]  index;
    logic [lfwoc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/lidar_front_wall_obstacle_classifier.sv =====
// The result of a scan is written from the read-modify-write stage into the result queue.
// Throughput: one sample per cycle outside the waits below, set by the single histogram
// read-modify-write per beat. The last sample of a scan waits while the idle histogram bank
// is still being scrubbed (only after the scan length shrinks) or while the two-entry result
// queue is full. Reset: registers take their reset values; both histogram banks are then swept
// to zero, all HIST_BINS bins, with sample ready low. Configuration beats are taken throughout.
module lidar_front_wall_obstacle_classifier (
    input  logic         clk,
    input  logic         rst_n,
    lfwoc_in_if.sink     samples,
    lfwoc_cfg_if.sink    cfg,
    lfwoc_out_if.source  results
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lfwoc_pkg::LEN_W-1:0]   scan_samples_reg;
    logic [lfwoc_pkg::RANGE_W-1:0] threshold_reg;
    logic [lfwoc_pkg::REP_W-1:0]   wall_limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_samples_reg <= lfwoc_pkg::SCAN_SAMPLES_RST;
            threshold_reg    <= lfwoc_pkg::THRESHOLD_RST;
            wall_limit_reg   <= lfwoc_pkg::WALL_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lfwoc_pkg::REG_SCAN_SAMPLES:
                    scan_samples_reg <= cfg.data[lfwoc_pkg::LEN_W-1:0];
                lfwoc_pkg::REG_OBSTACLE_THRESHOLD:
                    threshold_reg <= cfg.data[lfwoc_pkg::RANGE_W-1:0];
                lfwoc_pkg::REG_WALL_REPEAT_LIMIT:
                    wall_limit_reg <= cfg.data[lfwoc_pkg::REP_W-1:0];
                default:
                    ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Storage. Two histogram banks alternate per scan: one collects the
    // current scan, the other is scrubbed back to zero. Each bank keeps a
    // list of the bins it touched, so scrubbing visits only those entries
    // rather than a full sweep.
    // ------------------------------------------------------------------
    logic [lfwoc_pkg::HCNT_W-1:0] hist_mem [2][lfwoc_pkg::HIST_BINS];
    logic [lfwoc_pkg::BIN_W-1:0]  list_mem [2][lfwoc_pkg::MAX_SAMPLES];

    // Control state
    logic                          init_busy_reg;
    logic [lfwoc_pkg::BIN_W-1:0]   init_ptr_reg;
    logic                          bank_reg;
    logic [lfwoc_pkg::IDX_W-1:0]   idx_reg;
    logic [lfwoc_pkg::RANGE_W-1:0] min_reg;
    logic                          any_reg;
    logic [lfwoc_pkg::CNT_W-1:0]   list_cnt_reg;
    logic [lfwoc_pkg::CNT_W-1:0]   clr_left_reg;
    logic [lfwoc_pkg::IDX_W-1:0]   clr_ptr_reg;
    logic                          clr_pend_reg;
    logic [lfwoc_pkg::BIN_W-1:0]   clr_addr_reg;
    logic [lfwoc_pkg::REP_W-1:0]   rep_reg;

    // Read-modify-write stage
    logic                          s1_valid_reg;
    logic                          s1_upd_reg;
    logic                          s1_wr_reg;
    logic                          s1_last_reg;
    logic                          s1_bank_reg;
    logic [lfwoc_pkg::BIN_W-1:0]   s1_bin_reg;
    logic [lfwoc_pkg::RANGE_W-1:0] s1_min_reg;
    logic                          s1_any_reg;
    logic [lfwoc_pkg::HCNT_W-1:0]  hist_rd_reg [2];

    // Bypass of the write made at the same edge as the stage's read
    logic                          fwd_valid_reg;
    logic                          fwd_bank_reg;
    logic [lfwoc_pkg::BIN_W-1:0]   fwd_addr_reg;
    logic [lfwoc_pkg::HCNT_W-1:0]  fwd_cnt_reg;

    // Result queue
    lfwoc_pkg::result_t            q_mem_reg [2];
    logic                          q_wr_reg;
    logic                          q_rd_reg;
    logic [1:0]                    q_cnt_reg;

    // ------------------------------------------------------------------
    // Scan geometry from the current length
    // ------------------------------------------------------------------
    logic [lfwoc_pkg::CNT_W-1:0] scan_len;
    logic [lfwoc_pkg::CNT_W-1:0] last_idx;
    logic [lfwoc_pkg::CNT_W-1:0] win_lo;
    logic [lfwoc_pkg::CNT_W-1:0] win_hi_raw;
    logic [lfwoc_pkg::CNT_W-1:0] win_hi;
    logic [lfwoc_pkg::CNT_W-1:0] idx_ext;
    logic                        in_window;
    logic                        is_last;

    always_comb
    begin
        priority if (scan_samples_reg == '0)
            scan_len = lfwoc_pkg::CNT_W'(1);
        else if (int'(scan_samples_reg) > lfwoc_pkg::MAX_SAMPLES)
            scan_len = lfwoc_pkg::CNT_W'(lfwoc_pkg::MAX_SAMPLES);
        else
            scan_len = lfwoc_pkg::CNT_W'(scan_samples_reg);

        last_idx   = scan_len - 1'b1;
        win_lo     = (scan_len >> 1) - (scan_len >> 2);
        win_hi_raw = (scan_len >> 1) + (scan_len >> 2);
        win_hi     = (win_hi_raw > last_idx) ? last_idx : win_hi_raw;
        idx_ext    = lfwoc_pkg::CNT_W'(idx_reg);
        in_window  = (idx_ext >= win_lo) && (idx_ext <= win_hi);
        is_last    = (idx_ext >= last_idx);
    end

    // ------------------------------------------------------------------
    // Centimetre bin of the incoming beat
    // ------------------------------------------------------------------
    logic [lfwoc_pkg::PROD_W-1:0]    cm_prod;
    logic [lfwoc_pkg::CM_FULL_W-1:0] cm_full;
    logic [lfwoc_pkg::BIN_W-1:0]     in_bin;

    always_comb
    begin
        cm_prod = lfwoc_pkg::PROD_W'(samples.range_mm) * lfwoc_pkg::PROD_W'(lfwoc_pkg::CM_RECIP);
        cm_full = cm_prod[lfwoc_pkg::PROD_W-1:lfwoc_pkg::CM_SHIFT];
        // far ranges all land in the top bin
        if ((lfwoc_pkg::CM_FULL_W + 1)'(cm_full) >= (lfwoc_pkg::CM_FULL_W + 1)'(lfwoc_pkg::HIST_BINS))
            in_bin = lfwoc_pkg::BIN_W'(lfwoc_pkg::HIST_BINS - 1);
        else
            in_bin = cm_full[lfwoc_pkg::BIN_W-1:0];
    end

    // ------------------------------------------------------------------
    // Input handshake. Past the reset sweep, only the beat that closes a
    // scan can be held back: it swaps the banks, so the idle bank must be
    // fully scrubbed, and it produces a result, so the queue needs a slot.
    // ------------------------------------------------------------------
    logic q_push;
    logic q_pop;
    logic q_room;
    logic scrub_done;
    logic in_fire;
    logic upd;

    assign q_push     = s1_valid_reg && s1_last_reg;
    assign q_pop      = results.valid && results.ready;
    assign q_room     = (3'(q_cnt_reg) + 3'(q_push)) <= (3'd1 + 3'(q_pop));
    assign scrub_done = (clr_left_reg == '0) && !clr_pend_reg;

    assign samples.ready = !init_busy_reg && (!is_last || (scrub_done && q_room));
    assign in_fire       = samples.valid && samples.ready;
    assign upd           = !samples.no_return && in_window;

    // Running minimum including this beat
    logic [lfwoc_pkg::RANGE_W-1:0] min_next;
    logic                          any_next;

    always_comb
    begin
        min_next = (upd && (samples.range_mm < min_reg)) ? samples.range_mm : min_reg;
        any_next = any_reg || upd;
    end

    // ------------------------------------------------------------------
    // Read-modify-write of the histogram bin
    // ------------------------------------------------------------------
    logic [lfwoc_pkg::HCNT_W-1:0] old_cnt;
    logic [lfwoc_pkg::HCNT_W-1:0] new_cnt;
    logic                         rep_inc;
    logic [lfwoc_pkg::REP_W-1:0]  rep_next;
    lfwoc_pkg::result_t           res;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_bank_reg == s1_bank_reg) && (fwd_addr_reg == s1_bin_reg))
            old_cnt = fwd_cnt_reg;
        else
            old_cnt = hist_rd_reg[s1_bank_reg];

        new_cnt  = (old_cnt == lfwoc_pkg::HC_EMPTY) ? lfwoc_pkg::HC_ONCE : lfwoc_pkg::HC_REPEAT;
        rep_inc  = s1_upd_reg && (old_cnt == lfwoc_pkg::HC_ONCE) && (rep_reg != lfwoc_pkg::REP_MAX);
        rep_next = rep_reg + lfwoc_pkg::REP_W'(rep_inc);

        priority if (!s1_any_reg)
            res.class_code = lfwoc_pkg::CLS_NO_READING;
        else if (s1_min_reg > threshold_reg)
            res.class_code = lfwoc_pkg::CLS_CLEAR;
        else if (rep_next > wall_limit_reg)
            res.class_code = lfwoc_pkg::CLS_WALL;
        else
            res.class_code = lfwoc_pkg::CLS_OBSTACLE;
        res.front_min_mm    = s1_any_reg ? s1_min_reg : '0;
        res.repeated_values = rep_next;
    end

    // ------------------------------------------------------------------
    // Histogram write port per bank: init sweep, then scrub of the idle
    // bank, then the stage update of the active bank. The last two never
    // meet on one bank.
    // ------------------------------------------------------------------
    logic                         hw_en   [2];
    logic [lfwoc_pkg::BIN_W-1:0]  hw_addr [2];
    logic [lfwoc_pkg::HCNT_W-1:0] hw_data [2];

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            hw_en[b]   = 1'b0;
            hw_addr[b] = s1_bin_reg;
            hw_data[b] = new_cnt;
            priority if (init_busy_reg)
            begin
                hw_en[b]   = 1'b1;
                hw_addr[b] = init_ptr_reg;
                hw_data[b] = lfwoc_pkg::HC_EMPTY;
            end
            else if (clr_pend_reg && (bank_reg != 1'(b)))
            begin
                hw_en[b]   = 1'b1;
                hw_addr[b] = clr_addr_reg;
                hw_data[b] = lfwoc_pkg::HC_EMPTY;
            end
            else if (s1_valid_reg && s1_wr_reg && (s1_bank_reg == 1'(b)))
            begin
                hw_en[b] = 1'b1;
            end
            else
            begin
                hw_en[b] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 2; b++)
        begin
            if (hw_en[b])
                hist_mem[b][hw_addr[b]] <= hw_data[b];
            hist_rd_reg[b] <= hist_mem[b][in_bin];
        end
    end

    // Bin list: the active bank records, the idle bank is read back for scrub
    logic list_wr;

    assign list_wr = in_fire && upd && !is_last;

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 2; b++)
        begin
            if (list_wr && (bank_reg == 1'(b)))
                list_mem[b][list_cnt_reg[lfwoc_pkg::IDX_W-1:0]] <= in_bin;
        end
        clr_addr_reg <= list_mem[~bank_reg][clr_ptr_reg];
    end

    // ------------------------------------------------------------------
    // Scan state, scrub engine and init sweep
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_ptr_reg  <= '0;
            bank_reg      <= 1'b0;
            idx_reg       <= '0;
            min_reg       <= '1;
            any_reg       <= 1'b0;
            list_cnt_reg  <= '0;
            clr_left_reg  <= '0;
            clr_ptr_reg   <= '0;
            clr_pend_reg  <= 1'b0;
            rep_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (init_busy_reg)
            begin
                init_ptr_reg <= init_ptr_reg + 1'b1;
                if (init_ptr_reg == lfwoc_pkg::BIN_W'(lfwoc_pkg::HIST_BINS - 1))
                    init_busy_reg <= 1'b0;
            end

            // scrub: one list entry read per cycle, bin zeroed the cycle after
            if (clr_left_reg != '0)
            begin
                clr_left_reg <= clr_left_reg - 1'b1;
                clr_ptr_reg  <= clr_ptr_reg + 1'b1;
                clr_pend_reg <= 1'b1;
            end
            else
            begin
                clr_pend_reg <= 1'b0;
            end

            if (in_fire)
            begin
                if (is_last)
                begin
                    // close the scan: swap banks, start scrubbing the old one
                    idx_reg      <= '0;
                    min_reg      <= '1;
                    any_reg      <= 1'b0;
                    bank_reg     <= ~bank_reg;
                    list_cnt_reg <= '0;
                    clr_left_reg <= list_cnt_reg;
                    clr_ptr_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                    min_reg <= min_next;
                    any_reg <= any_next;
                    if (list_wr)
                        list_cnt_reg <= list_cnt_reg + 1'b1;
                end
            end

            s1_valid_reg  <= in_fire;
            fwd_valid_reg <= s1_valid_reg && s1_wr_reg;

            if (s1_valid_reg)
                rep_reg <= s1_last_reg ? '0 : rep_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        s1_upd_reg  <= upd;
        s1_wr_reg   <= upd && !is_last;
        s1_last_reg <= is_last;
        s1_bank_reg <= bank_reg;
        s1_bin_reg  <= in_bin;
        s1_min_reg  <= min_next;
        s1_any_reg  <= any_next;

        fwd_bank_reg <= s1_bank_reg;
        fwd_addr_reg <= s1_bin_reg;
        fwd_cnt_reg  <= new_cnt;

        if (q_push)
            q_mem_reg[q_wr_reg] <= res;
    end

    // ------------------------------------------------------------------
    // Result queue: two entries, so a waiting result does not hold the stream
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
                q_wr_reg <= ~q_wr_reg;
            if (q_pop)
                q_rd_reg <= ~q_rd_reg;
            q_cnt_reg <= q_cnt_reg + 2'(q_push) - 2'(q_pop);
        end
    end

    lfwoc_pkg::result_t q_head;

    assign q_head                  = q_mem_reg[q_rd_reg];
    assign results.valid           = (q_cnt_reg != '0);
    assign results.class_code      = q_head.class_code;
    assign results.front_min_mm    = q_head.front_min_mm;
    assign results.repeated_values = q_head.repeated_values;

endmodule

// ===== bench/lidar_front_wall_obstacle_classifier_tb.sv =====
`timescale 1ns / 1ps

module lidar_front_wall_obstacle_classifier_tb;

    // Index 3 decodes to no register; writes there must be dropped.
    localparam logic [lfwoc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RAND_ITEMS   = 1150;   // start no new random phase once this many samples are sent
    localparam int SETTLE       = 3;      // settle wait after every owed result has drained
    localparam int DRAIN        = 8;
    localparam int STALL_LIMIT  = 4000;   // covers the reset sweep with margin
    localparam int IDLE_PCT     = 15;
    localparam int CALM_FROM    = 300;    // no idling on either side in this sample range
    localparam int CALM_TO      = 550;

    typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t                         kind;
        logic [lfwoc_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [lfwoc_pkg::CFG_DATA_W-1:0]  reg_data;
        logic [lfwoc_pkg::RANGE_W-1:0]     range_mm;
        logic                              no_return;
        bit                                known;
        lfwoc_pkg::result_t                outcome;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lfwoc_in_if  smp_bus ();
    lfwoc_cfg_if cfg_bus ();
    lfwoc_out_if res_bus ();

    lidar_front_wall_obstacle_classifier u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp_bus),
        .cfg     (cfg_bus),
        .results (res_bus)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the classifier: register copies and per-scan state
    // ------------------------------------------------------------------
    logic [lfwoc_pkg::LEN_W-1:0]   scan_len_q;
    logic [lfwoc_pkg::RANGE_W-1:0] threshold_q;
    logic [lfwoc_pkg::REP_W-1:0]   wall_limit_q;

    int                            scan_pos;
    logic [lfwoc_pkg::RANGE_W-1:0] frontal_min;
    bit                            frontal_seen;
    logic [lfwoc_pkg::REP_W-1:0]   repeat_tally;
    logic [lfwoc_pkg::HCNT_W-1:0]  cm_hits [lfwoc_pkg::HIST_BINS];

    lfwoc_pkg::result_t pending_scans [$];   // classifications still owed by the block
    plan_row_t          plan [$];            // directed stimulus table

    int samples_sent;
    int scans_closed;
    int mismatches;
    int quiet_cycles;
    bit calm;

    function automatic void clear_scan_state();
        scan_pos     = 0;
        frontal_min  = '1;
        frontal_seen = 1'b0;
        repeat_tally = '0;
        foreach (cm_hits[i])
            cm_hits[i] = lfwoc_pkg::HC_EMPTY;
    endfunction

    // Fold one accepted sample into the shadow state. Return 1 when the
    // sample closes a scan, with the classification in verdict.
    function automatic bit classify_sample(input logic [lfwoc_pkg::RANGE_W-1:0] rng,
                                           input logic nr,
                                           output lfwoc_pkg::result_t verdict);
        int n;
        int lo;
        int hi;
        int cm;
        n = scan_len_q;
        if (n == 0)
            n = 1;
        if (n > lfwoc_pkg::MAX_SAMPLES)
            n = lfwoc_pkg::MAX_SAMPLES;
        // Frontal window always follows the length in force right now.
        lo = n / 2 - n / 4;
        hi = n / 2 + n / 4;
        if (hi > n - 1)
            hi = n - 1;
        if (!nr && scan_pos >= lo && scan_pos <= hi)
        begin
            cm = int'(rng) / 10;
            if (cm >= lfwoc_pkg::HIST_BINS)
                cm = lfwoc_pkg::HIST_BINS - 1;   // far ranges pile into the top bin
            if (rng < frontal_min)
                frontal_min = rng;
            frontal_seen = 1'b1;
            if (cm_hits[cm] == lfwoc_pkg::HC_EMPTY)
                cm_hits[cm] = lfwoc_pkg::HC_ONCE;
            else if (cm_hits[cm] == lfwoc_pkg::HC_ONCE)
            begin
                cm_hits[cm] = lfwoc_pkg::HC_REPEAT;
                if (repeat_tally != lfwoc_pkg::REP_MAX)
                    repeat_tally++;
            end
        end
        // A shrunk length can leave scan_pos past the new end: close now.
        if (scan_pos < n - 1)
        begin
            scan_pos++;
            return 1'b0;
        end
        if (!frontal_seen)
            verdict.class_code = lfwoc_pkg::CLS_NO_READING;
        else if (frontal_min > threshold_q)
            verdict.class_code = lfwoc_pkg::CLS_CLEAR;
        else if (repeat_tally > wall_limit_q)
            verdict.class_code = lfwoc_pkg::CLS_WALL;
        else
            verdict.class_code = lfwoc_pkg::CLS_OBSTACLE;
        verdict.front_min_mm    = frontal_seen ? frontal_min : '0;
        verdict.repeated_values = repeat_tally;
        clear_scan_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void add_write(input logic [lfwoc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [lfwoc_pkg::CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '{kind: ROW_WRITE, default: '0};
        r.reg_idx  = idx;
        r.reg_data = data;
        plan = {plan, r};
    endfunction

    function automatic void add_sample(input logic [lfwoc_pkg::RANGE_W-1:0] rng,
                                       input logic nr);
        plan_row_t r;
        r = '{kind: ROW_SAMPLE, default: '0};
        r.range_mm  = rng;
        r.no_return = nr;
        plan = {plan, r};
    endfunction

    // Sample whose scan result is obvious enough to type in directly.
    function automatic void add_known(input logic [lfwoc_pkg::RANGE_W-1:0] rng,
                                      input logic nr,
                                      input lfwoc_pkg::class_t cls,
                                      input logic [lfwoc_pkg::RANGE_W-1:0] fmin,
                                      input logic [lfwoc_pkg::REP_W-1:0] rep);
        plan_row_t r;
        r = '{kind: ROW_SAMPLE, default: '0};
        r.range_mm                = rng;
        r.no_return               = nr;
        r.known                   = 1'b1;
        r.outcome.class_code      = cls;
        r.outcome.front_min_mm    = fmin;
        r.outcome.repeated_values = rep;
        plan = {plan, r};
    endfunction

    // ------------------------------------------------------------------
    // Drivers: every task starts and ends just after a falling edge
    // ------------------------------------------------------------------
    task automatic push_sample(input logic [lfwoc_pkg::RANGE_W-1:0] rng, input logic nr,
                               input bit known, input lfwoc_pkg::result_t typed_res);
        lfwoc_pkg::result_t verdict;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            smp_bus.valid = 1'b0;
            @(negedge clk);
        end
        smp_bus.valid     = 1'b1;
        smp_bus.range_mm  = rng;
        smp_bus.no_return = nr;
        do
            @(posedge clk);
        while (!smp_bus.ready);
        if (classify_sample(rng, nr, verdict))
        begin
            if (known)
                verdict = typed_res;
            pending_scans = {pending_scans, verdict};
            scans_closed++;
        end
        samples_sent++;
        calm = (samples_sent >= CALM_FROM && samples_sent < CALM_TO);
        @(negedge clk);
    endtask

    // Hold off until every owed result has drained, then let the block settle.
    task automatic wait_quiet();
        smp_bus.valid = 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [lfwoc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfwoc_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            lfwoc_pkg::REG_SCAN_SAMPLES:       scan_len_q   = data[lfwoc_pkg::LEN_W-1:0];
            lfwoc_pkg::REG_OBSTACLE_THRESHOLD: threshold_q  = data[lfwoc_pkg::RANGE_W-1:0];
            lfwoc_pkg::REG_WALL_REPEAT_LIMIT:  wall_limit_q = data[lfwoc_pkg::REP_W-1:0];
            default: ;   // drop writes to the spare index
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, with a calm stretch
    // ------------------------------------------------------------------
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_bus.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each result beat with the oldest owed classification.
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            lfwoc_pkg::result_t want;
            if (pending_scans.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, got class %0d min %0d rep %0d",
                         $time, res_bus.class_code, res_bus.front_min_mm,
                         res_bus.repeated_values);
                mismatches++;
            end
            else
            begin
                want = pending_scans.pop_front();
                if (res_bus.class_code !== want.class_code)
                begin
                    $display("%0t ns: class_code mismatch: expected %0d, got %0d",
                             $time, want.class_code, res_bus.class_code);
                    mismatches++;
                end
                if (res_bus.front_min_mm !== want.front_min_mm)
                begin
                    $display("%0t ns: front_min_mm mismatch: expected %0d, got %0d",
                             $time, want.front_min_mm, res_bus.front_min_mm);
                    mismatches++;
                end
                if (res_bus.repeated_values !== want.repeated_values)
                begin
                    $display("%0t ns: repeated_values mismatch: expected %0d, got %0d",
                             $time, want.repeated_values, res_bus.repeated_values);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((smp_bus.valid && smp_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
                (res_bus.valid && res_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("lidar_front_wall_obstacle_classifier regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int                               phase;
        int                               n_eff;
        int                               count;
        int                               base;
        int                               spread;
        int                               thr;
        bit                               noisy;
        bit                               full_scan;
        logic [lfwoc_pkg::CFG_DATA_W-1:0] len_data;
        logic [lfwoc_pkg::RANGE_W-1:0]    rng;
        logic                             nr;

        samples_sent = 0;
        scans_closed = 0;
        mismatches   = 0;
        calm         = 1'b0;

        rst_n             = 1'b0;
        smp_bus.valid     = 1'b0;
        smp_bus.range_mm  = '0;
        smp_bus.no_return = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = lfwoc_pkg::REG_SCAN_SAMPLES;
        cfg_bus.data      = '0;

        scan_len_q   = lfwoc_pkg::SCAN_SAMPLES_RST;
        threshold_q  = lfwoc_pkg::THRESHOLD_RST;
        wall_limit_q = lfwoc_pkg::WALL_LIMIT_RST;
        clear_scan_state();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One-sample scans: every sample closes a scan on its own.
        add_write(lfwoc_pkg::REG_SCAN_SAMPLES, 16'd1);
        add_known(16'd0,     1'b0, lfwoc_pkg::CLS_OBSTACLE,   16'd0,     11'd0);
        add_known(16'hFFFF,  1'b0, lfwoc_pkg::CLS_CLEAR,      16'hFFFF,  11'd0);
        add_known(16'h5A5A,  1'b1, lfwoc_pkg::CLS_NO_READING, 16'd0,     11'd0);
        // Zero length behaves as one; threshold boundary at the reset value.
        add_write(lfwoc_pkg::REG_SCAN_SAMPLES, 16'd0);
        add_known(16'hFFFF,  1'b1, lfwoc_pkg::CLS_NO_READING, 16'd0,     11'd0);
        add_known(16'd300,   1'b0, lfwoc_pkg::CLS_OBSTACLE,   16'd300,   11'd0);
        add_known(16'd301,   1'b0, lfwoc_pkg::CLS_CLEAR,      16'd301,   11'd0);
        // Four-sample scans, window [1,3]: repeats within a bin and far ranges.
        add_write(lfwoc_pkg::REG_OBSTACLE_THRESHOLD, 16'hFFFF);
        add_write(lfwoc_pkg::REG_WALL_REPEAT_LIMIT, 16'd0);
        add_write(lfwoc_pkg::REG_SCAN_SAMPLES, 16'd4);
        add_sample(16'd5000,  1'b0);
        add_sample(16'd100,   1'b0);
        add_sample(16'd109,   1'b0);
        add_sample(16'd10240, 1'b0);
        add_sample(16'd0,     1'b1);
        add_sample(16'hFFFF,  1'b0);
        add_sample(16'd10230, 1'b0);
        add_sample(16'd10239, 1'b0);
        // Shrink the length mid-scan: the next sample closes the scan.
        add_write(lfwoc_pkg::REG_SCAN_SAMPLES, 16'd8);
        add_sample(16'd7,     1'b0);
        add_sample(16'd17,    1'b0);
        add_sample(16'd3,     1'b0);
        add_sample(16'd9,     1'b0);
        add_sample(16'd65534, 1'b0);
        add_write(lfwoc_pkg::REG_SCAN_SAMPLES, 16'd3);
        add_sample(16'd42,    1'b0);
        // Overlong length clamps to the maximum; spare index is ignored.
        add_write(lfwoc_pkg::REG_SCAN_SAMPLES, 16'hFFFF);
        add_sample(16'd1,     1'b0);
        add_sample(16'd2,     1'b0);
        add_write(REG_SPARE, 16'd1);
        add_write(lfwoc_pkg::REG_SCAN_SAMPLES, 16'd2);
        add_sample(16'd500,   1'b0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                wait_quiet();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end
            else
                push_sample(plan[i].range_mm, plan[i].no_return, plan[i].known,
                            plan[i].outcome);
        end

        // Random phases: settle, reprogram a random subset of registers, stream.
        phase = 0;
        while (samples_sent < RAND_ITEMS)
        begin
            wait_quiet();
            full_scan = (phase == 3);

            // Mostly short scans; once a full-size scan; now and then the maximum
            // length with only a few samples, so the next phase shrinks mid-scan.
            len_data = 16'($urandom_range(0, 12));
            len_data[lfwoc_pkg::CFG_DATA_W-1:lfwoc_pkg::LEN_W] = 5'($urandom);
            if (full_scan)
                write_reg(lfwoc_pkg::REG_SCAN_SAMPLES, 16'hFFFF);
            else if ($urandom_range(0, 11) == 0)
            begin
                len_data[lfwoc_pkg::LEN_W-1:0] = 11'(lfwoc_pkg::MAX_SAMPLES);
                write_reg(lfwoc_pkg::REG_SCAN_SAMPLES, len_data);
            end
            else if ($urandom_range(0, 3) != 0)
                write_reg(lfwoc_pkg::REG_SCAN_SAMPLES, len_data);

            noisy  = ($urandom_range(0, 4) == 0);
            spread = $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0)
                base = $urandom_range(0, 65535 - 40);
            else
                base = $urandom_range(0, 3000);

            case ($urandom_range(0, 5))
                0: ;
                1: write_reg(lfwoc_pkg::REG_OBSTACLE_THRESHOLD, 16'd0);
                2: write_reg(lfwoc_pkg::REG_OBSTACLE_THRESHOLD, 16'hFFFF);
                3: write_reg(lfwoc_pkg::REG_OBSTACLE_THRESHOLD, 16'($urandom));
                default:
                begin
                    // Place the threshold inside the cluster so classes split.
                    thr = base + $urandom_range(0, spread + 20) - 10;
                    if (thr < 0)
                        thr = 0;
                    if (thr > 65535)
                        thr = 65535;
                    write_reg(lfwoc_pkg::REG_OBSTACLE_THRESHOLD, 16'(thr));
                end
            endcase

            case ($urandom_range(0, 5))
                0: ;
                1: write_reg(lfwoc_pkg::REG_WALL_REPEAT_LIMIT, {5'($urandom), 11'h7FF});
                2: write_reg(lfwoc_pkg::REG_WALL_REPEAT_LIMIT,
                             {5'($urandom), 11'(lfwoc_pkg::MAX_SAMPLES)});
                default: write_reg(lfwoc_pkg::REG_WALL_REPEAT_LIMIT,
                                   {5'($urandom), 11'($urandom_range(0, 4))});
            endcase

            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, 16'($urandom));

            n_eff = scan_len_q;
            if (n_eff == 0)
                n_eff = 1;
            if (n_eff > lfwoc_pkg::MAX_SAMPLES)
                n_eff = lfwoc_pkg::MAX_SAMPLES;
            if (full_scan)
                count = n_eff - scan_pos;
            else if (n_eff >= lfwoc_pkg::MAX_SAMPLES)
                count = $urandom_range(1, 30);
            else
                count = $urandom_range(1, 5 * n_eff);

            repeat (count)
            begin
                if (noisy)
                begin
                    rng = 16'($urandom);
                    nr  = 1'($urandom_range(0, 1));
                end
                else
                begin
                    rng = 16'(base + $urandom_range(0, spread));
                    nr  = ($urandom_range(0, 99) < 8);
                end
                push_sample(rng, nr, 1'b0, '0);
            end
            phase++;
        end

        // Drain: hold until nothing is owed, then watch for stray beats.
        smp_bus.valid = 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0)
            $display("lidar_front_wall_obstacle_classifier regression: pass");
        else
            $display("lidar_front_wall_obstacle_classifier regression: fail");
        $finish;
    end

endmodule
